// File: src/sliding_window_mode_top_assert.svh
// Assertion macros shared by the sliding window mode block.
`ifndef SLIDING_WINDOW_MODE_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MODE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swm: same-cycle check failed");

// next-cycle implication, checked out of reset
`define SWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swm: next-cycle check failed");

`endif

// File: src/swm_pkg.sv
package swm_pkg;

  localparam int WINDOW_MAX_DEF = 64;
  localparam int VALUE_BITS_DEF = 16;
  localparam int SAMPLE_W       = 16;
  localparam int CFG_W          = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd8;
  localparam int GROUP          = 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RED1,
    S_RED2
  } state_t;

  typedef struct packed {
    logic load;
    logic red1;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic fire;
    logic out_free;
  } status_t;

endpackage

// File: src/swm_ctrl.sv
module swm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  swm_pkg::status_t status,
  output swm_pkg::cmd_t    cmd
);

  swm_pkg::state_t state_r, state_nxt;
  logic accept;

  assign accept = in_valid && (state_r == swm_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swm_pkg::S_IDLE: begin
        if (accept && status.fire) state_nxt = swm_pkg::S_RED1;
      end
      swm_pkg::S_RED1: state_nxt = swm_pkg::S_RED2;
      swm_pkg::S_RED2: begin
        if (status.out_free) state_nxt = swm_pkg::S_IDLE;
      end
      default: state_nxt = swm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      swm_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      swm_pkg::S_RED1: cmd.red1 = 1'b1;
      swm_pkg::S_RED2: cmd.emit = status.out_free;
      default: cmd = '0;
    endcase
  end

  `include "sliding_window_mode_top_assert.svh"

  `SWM_ASSERT_NEXT(a_fire_starts_reduce, accept && status.fire, state_r == swm_pkg::S_RED1)
  `SWM_ASSERT_NEXT(a_red1_then_red2, state_r == swm_pkg::S_RED1, state_r == swm_pkg::S_RED2)
  `SWM_ASSERT_NOW(a_busy_stalls, state_r != swm_pkg::S_IDLE, in_stall && !cmd.load)

endmodule

// File: src/swm_dp.sv
module swm_dp #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
  parameter int VALUE_BITS = swm_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic [swm_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swm_pkg::SAMPLE_W-1:0]  out_mode_value,
  input  swm_pkg::cmd_t                 cmd,
  output swm_pkg::status_t              status
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = $clog2(WINDOW_MAX);
  localparam int CMP_W = (LEN_W > swm_pkg::CFG_W) ? LEN_W : swm_pkg::CFG_W;
  localparam int NGRP  = (WINDOW_MAX + swm_pkg::GROUP - 1) / swm_pkg::GROUP;

  logic [swm_pkg::CFG_W-1:0] wlen_r;
  logic [LEN_W-1:0]          fill_r, fill_nxt, eff_len, last;
  logic [CMP_W-1:0]          wl_ext;
  logic [VALUE_BITS-1:0]     val_r [WINDOW_MAX];
  logic [LEN_W-1:0]          cnt_r [WINDOW_MAX];
  logic [VALUE_BITS-1:0]     grp_val_r [NGRP];
  logic [LEN_W-1:0]          grp_cnt_r [NGRP];
  logic [VALUE_BITS-1:0]     grp_val [NGRP];
  logic [LEN_W-1:0]          grp_cnt [NGRP];
  logic [LEN_W-1:0]          cnt_upd [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]     kept;
  logic [VALUE_BITS-1:0]     s_val, e_val, best_val;
  logic [LEN_W-1:0]          new_cnt, best_cnt;
  logic                      full, any_match, out_valid_r;
  logic [swm_pkg::SAMPLE_W-1:0] mode_r;

  assign s_val  = VALUE_BITS'(in_sample);
  assign wl_ext = CMP_W'(wlen_r);

  always_comb begin
    if (wlen_r == '0) eff_len = LEN_W'(1);
    else if (wl_ext > CMP_W'(WINDOW_MAX)) eff_len = LEN_W'(WINDOW_MAX);
    else eff_len = LEN_W'(wl_ext);
  end

  assign last  = eff_len - LEN_W'(1);
  assign full  = (fill_r == eff_len);
  assign e_val = val_r[last[IDX_W-1:0]];

  // per-tap count in the window after this beat
  always_comb begin
    new_cnt   = '0;
    any_match = 1'b0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      kept[i]    = (LEN_W'(i) < fill_r) && !(full && (LEN_W'(i) == last));
      cnt_upd[i] = cnt_r[i] + LEN_W'(val_r[i] == s_val)
                   - LEN_W'(full && (val_r[i] == e_val));
      if (kept[i] && (val_r[i] == s_val)) begin
        any_match = 1'b1;
        new_cnt   = new_cnt | cnt_upd[i];
      end
    end
    if (!any_match) new_cnt = LEN_W'(1);
  end

  assign fill_nxt = full ? fill_r : fill_r + LEN_W'(1);

  assign status.fire     = full || (fill_nxt == eff_len);
  assign status.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= swm_pkg::CFG_RESET;
      fill_r <= '0;
    end else if (cfg_wr_en) begin
      wlen_r <= cfg_wr_data;
      fill_r <= '0;
    end else if (cmd.load) begin
      fill_r <= fill_nxt;
    end
  end

  // shift the window: new beat in at tap zero, evicted tap drops its count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r[0] <= s_val;
      cnt_r[0] <= new_cnt;
      for (int i = 1; i < WINDOW_MAX; i++) begin
        val_r[i] <= val_r[i-1];
        cnt_r[i] <= kept[i-1] ? cnt_upd[i-1] : '0;
      end
    end
  end

  // first reduction level: best of each group of taps
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_val[g] = val_r[g*swm_pkg::GROUP];
      grp_cnt[g] = cnt_r[g*swm_pkg::GROUP];
      for (int k = 1; k < swm_pkg::GROUP; k++) begin
        if (g*swm_pkg::GROUP + k < WINDOW_MAX) begin
          if ((cnt_r[g*swm_pkg::GROUP+k] > grp_cnt[g]) ||
              ((cnt_r[g*swm_pkg::GROUP+k] == grp_cnt[g]) &&
               (val_r[g*swm_pkg::GROUP+k] < grp_val[g]))) begin
            grp_val[g] = val_r[g*swm_pkg::GROUP+k];
            grp_cnt[g] = cnt_r[g*swm_pkg::GROUP+k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.red1) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_val_r[g] <= grp_val[g];
        grp_cnt_r[g] <= grp_cnt[g];
      end
    end
  end

  // second level over the group winners
  always_comb begin
    best_val = grp_val_r[0];
    best_cnt = grp_cnt_r[0];
    for (int g = 1; g < NGRP; g++) begin
      if ((grp_cnt_r[g] > best_cnt) ||
          ((grp_cnt_r[g] == best_cnt) && (grp_val_r[g] < best_val))) begin
        best_val = grp_val_r[g];
        best_cnt = grp_cnt_r[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) mode_r <= swm_pkg::SAMPLE_W'(best_val);
  end

  assign out_valid      = out_valid_r;
  assign out_mode_value = mode_r;

  `include "sliding_window_mode_top_assert.svh"

  `SWM_ASSERT_NOW(a_fill_in_range, 1'b1, fill_r <= eff_len)
  `SWM_ASSERT_NOW(a_emit_slot_free, cmd.emit, !out_valid_r || !out_stall)
  `SWM_ASSERT_NEXT(a_cfg_empties, cfg_wr_en, fill_r == '0)

endmodule

// File: src/sliding_window_mode_top.sv
// A beat that completes the window updates the taps on acceptance; the group winners are
// then registered (S_RED1) and the mode is registered into the output (S_RED2). No new beat
// is taken in S_RED1 or S_RED2; beats that do not fill the window are taken every cycle.
// A waiting result sits in the output register while the next beat is taken.
// Reset (rst_n low, synchronous): window emptied, window_length set to 8, no result pending.
module sliding_window_mode_top #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
  parameter int VALUE_BITS = swm_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [swm_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [swm_pkg::SAMPLE_W-1:0] out_mode_value
);

  swm_pkg::cmd_t    cmd;
  swm_pkg::status_t status;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  swm_dp #(
    .WINDOW_MAX (WINDOW_MAX),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mode_value (out_mode_value),
    .cmd            (cmd),
    .status         (status)
  );

endmodule
